[hdl/kcet_pkg.sv]
// ----------------------------------------------------------------------------
// kcet_pkg
// shared types and constants of the cooldown expiry table
// ----------------------------------------------------------------------------
package kcet_pkg;

	localparam int DefTableSlots = 32;
	localparam int DefKindBits   = 4;

	localparam int FuncW   = 2;
	localparam int EntityW = 32;
	localparam int KindInW = 4;
	localparam int FrameW  = 32;
	localparam int LiveW   = 6;

	// operation codes
	localparam logic [FuncW-1:0] OpAge   = 2'd0;
	localparam logic [FuncW-1:0] OpQuery = 2'd1;
	localparam logic [FuncW-1:0] OpAdd   = 2'd2;

	// result of the shared compare unit
	typedef struct packed {
		logic key_eq;
		logic expired;
	} cmp_res_t;

endpackage

[hdl/kcet_cmp.sv]
// ----------------------------------------------------------------------------
// kcet_cmp
// shared compare unit: key equality and expiry check of one slot
// ----------------------------------------------------------------------------
module kcet_cmp #(
	parameter int KEY_W = 2 * kcet_pkg::EntityW + kcet_pkg::DefKindBits
) (
	input  logic [KEY_W-1:0]             slot_key,
	input  logic [kcet_pkg::FrameW-1:0]  slot_exp,
	input  logic [KEY_W-1:0]             req_key,
	input  logic [kcet_pkg::FrameW-1:0]  now,
	output kcet_pkg::cmp_res_t           res
);

	always_comb begin
		res.key_eq  = (slot_key == req_key);
		res.expired = !(slot_exp > now);
	end

endmodule

[hdl/kcet_store.sv]
// ----------------------------------------------------------------------------
// kcet_store
// slot key and expiry memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module kcet_store #(
	parameter int TABLE_SLOTS = kcet_pkg::DefTableSlots,
	parameter int KEY_W       = 2 * kcet_pkg::EntityW + kcet_pkg::DefKindBits,
	localparam int AW         = $clog2(TABLE_SLOTS)
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [KEY_W-1:0]             rd_key,
	output logic [kcet_pkg::FrameW-1:0]  rd_exp,
	input  logic                         wr_key_en,
	input  logic                         wr_exp_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [KEY_W-1:0]             wr_key,
	input  logic [kcet_pkg::FrameW-1:0]  wr_exp
);

	logic [KEY_W-1:0]            key_mem [TABLE_SLOTS];
	logic [kcet_pkg::FrameW-1:0] exp_mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_exp_en) begin
			exp_mem[wr_addr] <= wr_exp;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_exp <= exp_mem[rd_addr];
		end
	end

endmodule

[hdl/kinded_cooldown_expiry_table_unit.sv]
// the result strobe is registered in the finish state, which follows the slot scan
// one transaction at a time: busy is high in the scan and finish states, start is ignored meanwhile
// the sequencer walks every slot through the one memory read port and compare unit
// an unused operation code skips the walk and goes straight to the finish state
// reset clears all valid bits and the live count at once, no clearing pass
// results cannot be stalled: done is high for exactly one cycle
// ----------------------------------------------------------------------------
// kinded_cooldown_expiry_table_unit
// cooldown table keyed by source, target and kind, with frame based aging
// ----------------------------------------------------------------------------
module kinded_cooldown_expiry_table_unit #(
	parameter int TABLE_SLOTS = kcet_pkg::DefTableSlots,
	parameter int KIND_BITS   = kcet_pkg::DefKindBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [kcet_pkg::FuncW-1:0]    func,
	input  logic [kcet_pkg::EntityW-1:0]  source_entity,
	input  logic [kcet_pkg::EntityW-1:0]  target_entity,
	input  logic [kcet_pkg::KindInW-1:0]  cooldown_kind,
	input  logic [kcet_pkg::FrameW-1:0]   frame_now,
	input  logic [kcet_pkg::FrameW-1:0]   hold_frames,
	output logic                          done,
	output logic                          found,
	output logic                          dropped,
	output logic [kcet_pkg::LiveW-1:0]    live_entries
);

	localparam int AW    = $clog2(TABLE_SLOTS);
	localparam int CW    = $clog2(TABLE_SLOTS + 1);
	localparam int KEY_W = 2 * kcet_pkg::EntityW + KIND_BITS;
	localparam logic [CW-1:0] LastIdx = CW'(TABLE_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                       state_q;
	logic [kcet_pkg::FuncW-1:0]   op_q;
	logic [KEY_W-1:0]             key_q;
	logic [kcet_pkg::FrameW-1:0]  now_q;
	logic [kcet_pkg::FrameW-1:0]  exp_q;
	logic [CW-1:0]                idx_q;
	logic                         pend_s1;
	logic [AW-1:0]                pidx_s1;
	logic                         hit_q;
	logic [AW-1:0]                hit_idx_q;
	logic                         free_q;
	logic [AW-1:0]                free_idx_q;
	logic [TABLE_SLOTS-1:0]       valid_q;
	logic [CW-1:0]                count_q;

	logic                         accept;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [KEY_W-1:0]             rd_key;
	logic [kcet_pkg::FrameW-1:0]  rd_exp;
	logic                         wr_key_en;
	logic                         wr_exp_en;
	logic [AW-1:0]                wr_addr;
	kcet_pkg::cmp_res_t           cmp;
	logic                         is_add;
	logic                         age_clear;
	logic                         insert;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign rd_en   = (state_q == ST_SCAN) && (idx_q != LastIdx);
	assign rd_addr = idx_q[AW-1:0];
	assign is_add  = (op_q == kcet_pkg::OpAdd);
	assign insert  = (state_q == ST_FINISH) && is_add && !hit_q && free_q;

	assign age_clear = pend_s1 && (op_q == kcet_pkg::OpAge) && valid_q[pidx_s1]
		&& cmp.expired;

	assign wr_exp_en = (state_q == ST_FINISH) && is_add && (hit_q || free_q);
	assign wr_key_en = insert;
	assign wr_addr   = hit_q ? hit_idx_q : free_idx_q;

	kcet_store #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.KEY_W       (KEY_W)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_exp    (rd_exp),
		.wr_key_en (wr_key_en),
		.wr_exp_en (wr_exp_en),
		.wr_addr   (wr_addr),
		.wr_key    (key_q),
		.wr_exp    (exp_q)
	);

	kcet_cmp #(
		.KEY_W (KEY_W)
	) u_cmp (
		.slot_key (rd_key),
		.slot_exp (rd_exp),
		.req_key  (key_q),
		.now      (now_q),
		.res      (cmp)
	);

	// transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= func;
			key_q <= {source_entity, target_entity, KIND_BITS'(cooldown_kind)};
			now_q <= frame_now;
			exp_q <= frame_now + hold_frames;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			pend_s1    <= 1'b0;
			pidx_s1    <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			valid_q    <= '0;
			count_q    <= '0;
			done       <= 1'b0;
			found      <= 1'b0;
			dropped    <= 1'b0;
			live_entries <= '0;
		end else begin
			done    <= 1'b0;
			pend_s1 <= rd_en;
			pidx_s1 <= rd_addr;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						if (func == kcet_pkg::OpAge || func == kcet_pkg::OpQuery
							|| func == kcet_pkg::OpAdd) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
						if (!valid_q[rd_addr] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_addr;
						end
					end
					if (pend_s1 && op_q != kcet_pkg::OpAge && valid_q[pidx_s1]
						&& cmp.key_eq && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= pidx_s1;
					end
					if (age_clear) begin
						valid_q[pidx_s1] <= 1'b0;
						count_q          <= count_q - 1'b1;
					end
					if (idx_q == LastIdx) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done    <= 1'b1;
					found   <= (op_q == kcet_pkg::OpQuery || is_add) && hit_q;
					dropped <= is_add && !hit_q && !free_q;
					if (insert) begin
						valid_q[free_idx_q] <= 1'b1;
						count_q             <= count_q + 1'b1;
						live_entries        <= kcet_pkg::LiveW'(count_q + 1'b1);
					end else begin
						live_entries <= kcet_pkg::LiveW'(count_q);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LastIdx)
		else $error("live count above table size");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE) && !$past(done))
		else $error("result strobe outside idle or longer than one cycle");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && dropped))
		else $error("found and dropped both set");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> (count_q == LastIdx))
		else $error("add dropped while the table had room");

endmodule
